### src/tdma_stt_pkg.sv
// Shared constants and codes for the TDMA slot timing tracker.
// No dependencies; used by tdma_slot_timing_tracker and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package tdma_stt_pkg;

	// Field widths
	localparam int TIME_W = 64;
	localparam int REG_W  = 32;
	localparam int OFF_W  = 32;
	localparam int ACT_W  = 2;
	localparam int TN_W   = 3;
	localparam int FN_W   = 5;
	localparam int MN_W   = 6;

	// Hyperframe geometry
	localparam int unsigned HYPERFRAME_SLOTS_DEF = 4320;
	localparam int unsigned FRAME_SLOTS          = 4;
	localparam int unsigned MF_SLOTS             = 72;

	// Resync reference: base = 72*mn + 4*fn + tn - SYNC_BIAS
	localparam int unsigned SYNC_BIAS = MF_SLOTS + FRAME_SLOTS + 1;
	// Largest base the field widths allow
	localparam int unsigned SYNC_SPAN = ((2 ** MN_W) - 1) * MF_SLOTS
		+ ((2 ** FN_W) - 1) * FRAME_SLOTS + ((2 ** TN_W) - 1) - SYNC_BIAS;

	// Step counter covers the 64 divide steps
	localparam int CNT_W = 7;

	// Register reset values
	localparam logic [REG_W-1:0] SLOT_PERIOD_RST = 32'd14166666;
	localparam logic [REG_W-1:0] LEAD_TIME_RST   = 32'd12500000;

	// Offset saturation limits
	localparam logic [OFF_W-1:0] OFF_MAX = 32'h7FFF_FFFF;
	localparam logic [OFF_W-1:0] OFF_MIN = 32'h8000_0000;

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK = 2'd0,
		ACT_RX   = 2'd1,
		ACT_SYNC = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic {
		REG_SLOT_PERIOD = 1'b0,
		REG_LEAD_TIME   = 1'b1
	} reg_index_t;

endpackage

`default_nettype wire

### src/tdma_slot_timing_tracker.sv
// TDMA slot timing tracker: tx slot scheduling, rx slot placement, resync.
// Depends on tdma_stt_pkg for widths, codes and reset values.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the next transmit slot time and its index in a hyperframe of
// HYPERFRAME_SLOTS slots and returns exactly one result per item. One item
// is worked on at a time. Below, V is the bit count of the serial mod unit
// (14 at the default hyperframe). A tick passes the seed, add, difference and
// fire-test states; when it fires, the serial unit then splits the slot index
// into tn, fn and mn by a serial divide by 72, else the tick ends after the
// test. A received burst runs the 64-step restoring divider, one quotient bit
// per cycle, then the serial unit. A resync first reduces the reference index
// mod HYPERFRAME_SLOTS serially, and when it is behind the tx slot time it
// then also runs the divider. An unused action goes straight to the result.
// A stalled output holds the sequencer in its final state until the output
// register is free. The next item is taken as soon as the sequencer is idle,
// while an earlier result may still wait in the output register.
module tdma_slot_timing_tracker #(
	parameter int unsigned HYPERFRAME_SLOTS = tdma_stt_pkg::HYPERFRAME_SLOTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_index,
	input  logic [tdma_stt_pkg::REG_W-1:0]        cfg_data,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [tdma_stt_pkg::ACT_W-1:0]        action,
	input  logic [tdma_stt_pkg::TIME_W-1:0]       stamp,
	input  logic [tdma_stt_pkg::TN_W-1:0]         sync_tn,
	input  logic [tdma_stt_pkg::FN_W-1:0]         sync_fn,
	input  logic [tdma_stt_pkg::MN_W-1:0]         sync_mn,
	// results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  fired,
	output logic [tdma_stt_pkg::TIME_W-1:0]       slot_stamp,
	output logic signed [tdma_stt_pkg::OFF_W-1:0] offset,
	output logic [tdma_stt_pkg::TN_W-1:0]         out_tn,
	output logic [tdma_stt_pkg::FN_W-1:0]         out_fn,
	output logic [tdma_stt_pkg::MN_W-1:0]         out_mn
);

	localparam int TW    = tdma_stt_pkg::TIME_W;
	localparam int RW    = tdma_stt_pkg::REG_W;
	localparam int CW    = tdma_stt_pkg::CNT_W;
	localparam int IDX_W = $clog2(HYPERFRAME_SLOTS);
	localparam int V_W   = $clog2(tdma_stt_pkg::SYNC_SPAN + 2 * HYPERFRAME_SLOTS + 1);

	localparam logic [IDX_W:0] HS  = (IDX_W + 1)'(HYPERFRAME_SLOTS);
	localparam logic [IDX_W:0] M72 = (IDX_W + 1)'(tdma_stt_pkg::MF_SLOTS);
	localparam logic [V_W-1:0] SYNC_OFS =
		V_W'(2 * HYPERFRAME_SLOTS - tdma_stt_pkg::SYNC_BIAS);

	typedef enum logic [19:0] {
		ST_IDLE    = 20'h00001,
		ST_T_SEED  = 20'h00002,
		ST_T_ADD   = 20'h00004,
		ST_T_DIFF  = 20'h00008,
		ST_T_FIRE  = 20'h00010,
		ST_R_DIFF  = 20'h00020,
		ST_R_ABS   = 20'h00040,
		ST_DIV     = 20'h00080,
		ST_R_ROUND = 20'h00100,
		ST_R_SIGN  = 20'h00200,
		ST_R_IDX   = 20'h00400,
		ST_S_LOAD  = 20'h00800,
		ST_S_BASE  = 20'h01000,
		ST_S_FIRST = 20'h02000,
		ST_S_DIFF  = 20'h04000,
		ST_S_NEG   = 20'h08000,
		ST_S_KMOD  = 20'h10000,
		ST_S_STEP  = 20'h20000,
		ST_SLOT    = 20'h40000,
		ST_FIN     = 20'h80000
	} state_t;

	state_t                         state_q;
	tdma_stt_pkg::action_t          act_q;
	logic [TW-1:0]                  stamp_q;
	logic [tdma_stt_pkg::TN_W-1:0]  tn_q;
	logic [tdma_stt_pkg::FN_W-1:0]  fn_q;
	logic [tdma_stt_pkg::MN_W-1:0]  mn_q;

	// config (period held as its effective value, zero reads as one)
	logic [RW-1:0]                  per_q;
	logic [RW-1:0]                  lead_q;

	// tracker state
	logic [TW-1:0]                  nxt_q;
	logic [IDX_W-1:0]               idx_q;

	// working registers
	logic [IDX_W-1:0]               base_q;
	logic                           seed_q;
	logic                           neg_q;
	logic                           round_q;
	logic [TW-1:0]                  w_q;
	logic [TW-1:0]                  dq_q;
	logic [RW-1:0]                  rem_q;
	logic [RW-1:0]                  mag_q;
	logic [CW-1:0]                  cnt_q;
	logic [V_W-1:0]                 nsh_q;
	logic [IDX_W-1:0]               nrem_q;
	logic [tdma_stt_pkg::MN_W-1:0]  nquo_q;

	// pending result
	logic                           res_fired_q;
	logic [TW-1:0]                  res_stamp_q;
	logic [tdma_stt_pkg::OFF_W-1:0] res_off_q;

	// output register
	logic                           out_valid_q;
	logic                           fired_q;
	logic [TW-1:0]                  slot_stamp_q;
	logic [tdma_stt_pkg::OFF_W-1:0] offset_q;
	logic [tdma_stt_pkg::TN_W-1:0]  out_tn_q;
	logic [tdma_stt_pkg::FN_W-1:0]  out_fn_q;
	logic [tdma_stt_pkg::MN_W-1:0]  out_mn_q;

	// combinational helpers
	logic [RW:0]       div_t;
	logic [RW+1:0]     div_diff;
	logic              div_bit;
	logic [RW-1:0]     div_rem;
	logic              nar_bit;
	logic [IDX_W:0]    nar_mod;
	logic [IDX_W:0]    nar_t;
	logic [IDX_W:0]    nar_sub;
	logic              nar_q;
	logic [IDX_W-1:0]  nar_rem;
	logic [TW-1:0]     w_mag;
	logic              tick_fire;
	logic              rx_round;
	logic              rnz;
	logic [IDX_W:0]    idx_p1;
	logic [IDX_W-1:0]  idx_inc;
	logic [IDX_W:0]    base_p1;
	logic [IDX_W-1:0]  base_inc;
	logic [IDX_W:0]    q_p1;
	logic [IDX_W-1:0]  q_inc;
	logic [IDX_W:0]    q_neg;
	logic [IDX_W:0]    ridx_sum;
	logic [IDX_W:0]    ridx_sub;
	logic [IDX_W-1:0]  ridx;
	logic [IDX_W:0]    ksum;
	logic [IDX_W:0]    ksub;
	logic [IDX_W-1:0]  kmod;
	logic [IDX_W:0]    sidx_sum;
	logic [IDX_W:0]    sidx_sub;
	logic [IDX_W-1:0]  sidx;
	logic [V_W-1:0]    sync_v;
	logic              rx_sign;
	logic              in_take;
	logic              out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign fired      = fired_q;
	assign slot_stamp = slot_stamp_q;
	assign offset     = offset_q;
	assign out_tn     = out_tn_q;
	assign out_fn     = out_fn_q;
	assign out_mn     = out_mn_q;

	// restoring divider step: one quotient bit per cycle
	always_comb begin
		div_t    = {rem_q, dq_q[TW-1]};
		div_diff = {1'b0, div_t} - {2'b00, per_q};
		div_bit  = !div_diff[RW+1];
		div_rem  = div_bit ? div_diff[RW-1:0] : div_t[RW-1:0];
	end

	// serial mod unit: rem = (2*rem + bit) mod M, quotient bits shifted out
	always_comb begin
		nar_bit = (state_q == ST_DIV) ? div_bit : nsh_q[V_W-1];
		nar_mod = (state_q == ST_SLOT) ? M72 : HS;
		nar_t   = {nrem_q, nar_bit};
		nar_sub = nar_t - nar_mod;
		nar_q   = (nar_t >= nar_mod);
		nar_rem = nar_q ? nar_sub[IDX_W-1:0] : nar_t[IDX_W-1:0];
	end

	// index arithmetic: sums that wrap at HYPERFRAME_SLOTS, plus the tick and rx tests
	always_comb begin
		w_mag     = ~w_q + 64'd1;
		// w = slot time - now; fire when now is past it or within lead time
		tick_fire = (w_q[TW-1] && (w_q[TW-2:0] != '0)) ||
			((w_q[TW-1:RW] == '0) && (w_q[RW-1:0] <= lead_q));
		rx_round  = ({rem_q, 1'b0} >= {1'b0, per_q});
		rnz       = (rem_q != '0);
		rx_sign   = round_q ^ neg_q;

		idx_p1   = {1'b0, idx_q} + (IDX_W + 1)'(1);
		idx_inc  = (idx_p1 == HS) ? '0 : idx_p1[IDX_W-1:0];
		base_p1  = {1'b0, base_q} + (IDX_W + 1)'(1);
		base_inc = (base_p1 == HS) ? '0 : base_p1[IDX_W-1:0];
		q_p1     = {1'b0, nrem_q} + (IDX_W + 1)'(1);
		q_inc    = (q_p1 == HS) ? '0 : q_p1[IDX_W-1:0];
		q_neg    = HS - {1'b0, nrem_q};

		ridx_sum = {1'b0, idx_q} + {1'b0, nrem_q};
		ridx_sub = ridx_sum - HS;
		ridx     = (ridx_sum >= HS) ? ridx_sub[IDX_W-1:0] : ridx_sum[IDX_W-1:0];

		ksum = {1'b0, nrem_q} + (IDX_W + 1)'(1) + (IDX_W + 1)'(rnz);
		ksub = ksum - HS;
		kmod = (ksum >= HS) ? ksub[IDX_W-1:0] : ksum[IDX_W-1:0];

		sidx_sum = {1'b0, base_q} + {1'b0, nrem_q};
		sidx_sub = sidx_sum - HS;
		sidx     = (sidx_sum >= HS) ? sidx_sub[IDX_W-1:0] : sidx_sum[IDX_W-1:0];

		// reference slot index biased non-negative by two hyperframes
		sync_v = V_W'(mn_q) * V_W'(tdma_stt_pkg::MF_SLOTS)
			+ V_W'(fn_q) * V_W'(tdma_stt_pkg::FRAME_SLOTS)
			+ V_W'(tn_q) + SYNC_OFS;
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= tdma_stt_pkg::ACT_NONE;
			stamp_q      <= '0;
			tn_q         <= '0;
			fn_q         <= '0;
			mn_q         <= '0;
			per_q        <= tdma_stt_pkg::SLOT_PERIOD_RST;
			lead_q       <= tdma_stt_pkg::LEAD_TIME_RST;
			nxt_q        <= '0;
			idx_q        <= '0;
			base_q       <= '0;
			seed_q       <= 1'b0;
			neg_q        <= 1'b0;
			round_q      <= 1'b0;
			w_q          <= '0;
			dq_q         <= '0;
			rem_q        <= '0;
			mag_q        <= '0;
			cnt_q        <= '0;
			nsh_q        <= '0;
			nrem_q       <= '0;
			nquo_q       <= '0;
			res_fired_q  <= 1'b0;
			res_stamp_q  <= '0;
			res_off_q    <= '0;
			out_valid_q  <= 1'b0;
			fired_q      <= 1'b0;
			slot_stamp_q <= '0;
			offset_q     <= '0;
			out_tn_q     <= '0;
			out_fn_q     <= '0;
			out_mn_q     <= '0;
		end else begin
			// config transfer
			if (cfg_valid && cfg_ready) begin
				unique case (tdma_stt_pkg::reg_index_t'(cfg_index))
					tdma_stt_pkg::REG_SLOT_PERIOD: begin
						per_q <= (cfg_data == '0) ? RW'(1) : cfg_data;
					end
					tdma_stt_pkg::REG_LEAD_TIME: begin
						lead_q <= cfg_data;
					end
				endcase
			end

			// result taken downstream; in ST_FIN the next result takes its place
			if (out_valid_q && !out_stall && (state_q != ST_FIN))
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						act_q       <= tdma_stt_pkg::action_t'(action);
						stamp_q     <= stamp;
						tn_q        <= sync_tn;
						fn_q        <= sync_fn;
						mn_q        <= sync_mn;
						res_fired_q <= 1'b0;
						unique case (tdma_stt_pkg::action_t'(action))
							tdma_stt_pkg::ACT_TICK: state_q <= ST_T_SEED;
							tdma_stt_pkg::ACT_RX:   state_q <= ST_R_DIFF;
							tdma_stt_pkg::ACT_SYNC: state_q <= ST_S_LOAD;
							tdma_stt_pkg::ACT_NONE: state_q <= ST_FIN;
						endcase
					end
				end

				// tick: seed on first use as now + lead + period
				ST_T_SEED: begin
					seed_q <= (nxt_q == '0);
					if (nxt_q == '0)
						nxt_q <= stamp_q + TW'(lead_q);
					state_q <= ST_T_ADD;
				end
				ST_T_ADD: begin
					if (seed_q)
						nxt_q <= nxt_q + TW'(per_q);
					state_q <= ST_T_DIFF;
				end
				ST_T_DIFF: begin
					w_q     <= nxt_q - stamp_q;
					state_q <= ST_T_FIRE;
				end
				ST_T_FIRE: begin
					if (tick_fire) begin
						res_fired_q <= 1'b1;
						res_stamp_q <= nxt_q;
						res_off_q   <= '0;
						nxt_q       <= nxt_q + TW'(per_q);
						nsh_q       <= V_W'(idx_q);
						nrem_q      <= '0;
						nquo_q      <= '0;
						cnt_q       <= CW'(V_W - 1);
						idx_q       <= idx_inc;
						state_q     <= ST_SLOT;
					end else begin
						state_q <= ST_FIN;
					end
				end

				// rx: distance from tx slot time, split into sign and magnitude
				ST_R_DIFF: begin
					w_q     <= stamp_q - nxt_q;
					state_q <= ST_R_ABS;
				end
				ST_R_ABS: begin
					neg_q   <= w_q[TW-1];
					dq_q    <= w_q[TW-1] ? w_mag : w_q;
					rem_q   <= '0;
					nrem_q  <= '0;
					nquo_q  <= '0;
					cnt_q   <= CW'(TW - 1);
					state_q <= ST_DIV;
				end

				// shared divider; quotient mod hyperframe tracked alongside
				ST_DIV: begin
					rem_q  <= div_rem;
					dq_q   <= {dq_q[TW-2:0], div_bit};
					nrem_q <= nar_rem;
					nquo_q <= {nquo_q[tdma_stt_pkg::MN_W-2:0], nar_q};
					if (cnt_q == '0) begin
						if (act_q == tdma_stt_pkg::ACT_RX)
							state_q <= ST_R_ROUND;
						else
							state_q <= ST_S_KMOD;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end

				// round half away from zero
				ST_R_ROUND: begin
					round_q <= rx_round;
					mag_q   <= rx_round ? (per_q - rem_q) : rem_q;
					if (rx_round)
						nrem_q <= q_inc;
					state_q <= ST_R_SIGN;
				end
				ST_R_SIGN: begin
					if (!rx_sign)
						res_off_q <= mag_q[RW-1] ? tdma_stt_pkg::OFF_MAX : mag_q;
					else if (mag_q > tdma_stt_pkg::OFF_MIN)
						res_off_q <= tdma_stt_pkg::OFF_MIN;
					else
						res_off_q <= ~mag_q + RW'(1);
					if (neg_q && (nrem_q != '0))
						nrem_q <= q_neg[IDX_W-1:0];
					state_q <= ST_R_IDX;
				end
				ST_R_IDX: begin
					res_fired_q <= 1'b1;
					res_stamp_q <= stamp_q;
					nsh_q       <= V_W'(ridx);
					nrem_q      <= '0;
					nquo_q      <= '0;
					cnt_q       <= CW'(V_W - 1);
					state_q     <= ST_SLOT;
				end

				// resync: reduce the reference index mod hyperframe serially
				ST_S_LOAD: begin
					nsh_q   <= sync_v;
					nrem_q  <= '0;
					nquo_q  <= '0;
					cnt_q   <= CW'(V_W - 1);
					state_q <= ST_S_BASE;
				end
				ST_S_BASE: begin
					nrem_q <= nar_rem;
					nquo_q <= {nquo_q[tdma_stt_pkg::MN_W-2:0], nar_q};
					nsh_q  <= {nsh_q[V_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						base_q  <= nar_rem;
						state_q <= ST_S_FIRST;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_S_FIRST: begin
					w_q     <= stamp_q + TW'(per_q);
					state_q <= ST_S_DIFF;
				end
				ST_S_DIFF: begin
					w_q     <= w_q - nxt_q;
					state_q <= ST_S_NEG;
				end
				ST_S_NEG: begin
					if (!w_q[TW-1]) begin
						// not behind: one slot past the reference
						nxt_q   <= stamp_q + TW'(per_q);
						idx_q   <= base_inc;
						state_q <= ST_FIN;
					end else begin
						dq_q    <= w_mag;
						rem_q   <= '0;
						nrem_q  <= '0;
						nquo_q  <= '0;
						cnt_q   <= CW'(TW - 1);
						state_q <= ST_DIV;
					end
				end
				// k = 1 + ceil(m/p); new slot time = old - r (+ p when r != 0)
				ST_S_KMOD: begin
					nrem_q  <= kmod;
					mag_q   <= per_q - rem_q;
					state_q <= ST_S_STEP;
				end
				ST_S_STEP: begin
					if (rnz)
						nxt_q <= nxt_q + TW'(mag_q);
					idx_q   <= sidx;
					state_q <= ST_FIN;
				end

				// slot index -> multiframe (quotient) and slot in multiframe
				ST_SLOT: begin
					nrem_q <= nar_rem;
					nquo_q <= {nquo_q[tdma_stt_pkg::MN_W-2:0], nar_q};
					nsh_q  <= {nsh_q[V_W-2:0], 1'b0};
					if (cnt_q == '0)
						state_q <= ST_FIN;
					else
						cnt_q <= cnt_q - CW'(1);
				end

				// hand the result to the output register
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						fired_q     <= res_fired_q;
						if (res_fired_q) begin
							slot_stamp_q <= res_stamp_q;
							offset_q     <= res_off_q;
							out_tn_q     <= {1'b0, nrem_q[1:0]} + 3'd1;
							out_fn_q     <= nrem_q[6:2] + 5'd1;
							out_mn_q     <= nquo_q + 6'd1;
						end else begin
							slot_stamp_q <= '0;
							offset_q     <= '0;
							out_tn_q     <= '0;
							out_fn_q     <= '0;
							out_mn_q     <= '0;
						end
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/tdma_slot_timing_tracker_tb.sv
// Self-checking testbench for the TDMA slot timing tracker: directed and random
// ticks, rx bursts and resyncs under several register settings, with random pacing.
// Depends on tdma_stt_pkg and tdma_slot_timing_tracker.
`timescale 1ns / 1ps

module tdma_slot_timing_tracker_tb;
	import tdma_stt_pkg::*;

	localparam int unsigned HF = HYPERFRAME_SLOTS_DEF;
	localparam int MAX_WAIT = 17;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE = 200;
	localparam int N_PHASES = 7;
	localparam int PHASE_ITEMS = 86;

	typedef struct {
		action_t           act;
		logic [TIME_W-1:0] stamp;
		logic [TN_W-1:0]   tn;
		logic [FN_W-1:0]   fn;
		logic [MN_W-1:0]   mn;
		bit                drain;
	} slot_item_t;

	typedef struct {
		logic                    fired;
		logic [TIME_W-1:0]       slot_stamp;
		logic signed [OFF_W-1:0] offset;
		logic [TN_W-1:0]         tn;
		logic [FN_W-1:0]         fn;
		logic [MN_W-1:0]         mn;
	} slot_report_t;

	typedef struct {
		logic [TIME_W-1:0] tx_stamp;
		int unsigned       tx_index;
		logic [REG_W-1:0]  period;
		logic [REG_W-1:0]  lead;
	} track_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = 1'b0;
	logic [REG_W-1:0] cfg_data = '0;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [ACT_W-1:0]  action = '0;
	logic [TIME_W-1:0] stamp = '0;
	logic [TN_W-1:0]   sync_tn = '0;
	logic [FN_W-1:0]   sync_fn = '0;
	logic [MN_W-1:0]   sync_mn = '0;

	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    fired;
	logic [TIME_W-1:0]       slot_stamp;
	logic signed [OFF_W-1:0] offset;
	logic [TN_W-1:0]         out_tn;
	logic [FN_W-1:0]         out_fn;
	logic [MN_W-1:0]         out_mn;

	slot_item_t   pending[$];
	slot_report_t expected[$];
	slot_item_t   cur_item;

	// checker copy of the block state and registers
	logic [TIME_W-1:0] exp_tx_stamp = '0;
	int unsigned       exp_tx_index = 0;
	logic [REG_W-1:0]  reg_period = SLOT_PERIOD_RST;
	logic [REG_W-1:0]  reg_lead = LEAD_TIME_RST;

	int n_sent = 0;
	int n_recv = 0;
	int n_err = 0;
	int pre_wait = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	tdma_slot_timing_tracker #(.HYPERFRAME_SLOTS(HF)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .stamp(stamp),
		.sync_tn(sync_tn), .sync_fn(sync_fn), .sync_mn(sync_mn),
		.out_valid(out_valid), .out_stall(out_stall), .fired(fired), .slot_stamp(slot_stamp),
		.offset(offset), .out_tn(out_tn), .out_fn(out_fn), .out_mn(out_mn)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pace_draw();
		return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	function automatic logic [TIME_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// zero period counts as one ns
	function automatic logic [TIME_W-1:0] step_len(input track_t st);
		return (st.period == '0) ? 64'd1 : {32'd0, st.period};
	endfunction

	function automatic void slot_numbers(input int unsigned idx, inout slot_report_t rep);
		rep.tn = TN_W'(idx % FRAME_SLOTS + 1);
		rep.fn = FN_W'((idx / FRAME_SLOTS) % (MF_SLOTS / FRAME_SLOTS) + 1);
		rep.mn = MN_W'(idx / MF_SLOTS + 1);
	endfunction

	// Slot tracking: one report per item, state advanced in place
	function automatic slot_report_t track_slot(input slot_item_t it, inout track_t st);
		slot_report_t rep;
		logic [TIME_W-1:0] p, d, m, q, r, lead_at, k;
		logic neg, due;
		longint res, base;
		int unsigned qmod;
		rep = '{fired: 1'b0, slot_stamp: '0, offset: '0, tn: '0, fn: '0, mn: '0};
		p = step_len(st);
		case (it.act)
			ACT_TICK: begin
				// first tick seeds the slot time
				if (st.tx_stamp == '0)
					st.tx_stamp = it.stamp + {32'd0, st.lead} + p;
				d = it.stamp - st.tx_stamp;
				due = !d[TIME_W-1] || ((-d) <= {32'd0, st.lead});
				if (due) begin
					rep.fired = 1'b1;
					rep.slot_stamp = st.tx_stamp;
					slot_numbers(st.tx_index, rep);
					st.tx_stamp = st.tx_stamp + p;
					st.tx_index = (st.tx_index + 1) % HF;
				end
			end
			ACT_RX: begin
				// nearest slot, ties away from zero
				d = it.stamp - st.tx_stamp;
				neg = d[TIME_W-1];
				m = neg ? -d : d;
				q = m / p;
				r = m % p;
				if (r >= p - r) begin
					q = q + 1;
					res = -$signed(p - r);
				end else
					res = $signed(r);
				if (neg)
					res = -res;
				if (res > longint'($signed(OFF_MAX)))
					res = longint'($signed(OFF_MAX));
				if (res < longint'($signed(OFF_MIN)))
					res = longint'($signed(OFF_MIN));
				qmod = 32'(q % 64'(HF));
				if (neg && qmod != 0)
					qmod = HF - qmod;
				rep.fired = 1'b1;
				rep.slot_stamp = it.stamp;
				rep.offset = res[OFF_W-1:0];
				slot_numbers((st.tx_index + qmod) % HF, rep);
			end
			ACT_SYNC: begin
				base = longint'(MF_SLOTS) * (longint'(it.mn) - 1)
					+ longint'(FRAME_SLOTS) * (longint'(it.fn) - 1) + longint'(it.tn) - 1;
				base = base % longint'(HF);
				if (base < 0)
					base = base + longint'(HF);
				// step forward until no longer behind the tx slot time
				lead_at = it.stamp + p;
				d = lead_at - st.tx_stamp;
				k = 64'd1;
				if (d[TIME_W-1]) begin
					m = -d;
					k = k + m / p + 64'((m % p) != 0);
				end
				st.tx_stamp = it.stamp + k * p;
				st.tx_index = 32'((64'(base) + k % 64'(HF)) % 64'(HF));
			end
			default: ;
		endcase
		return rep;
	endfunction

	task automatic queue_item(inout track_t sh, input action_t act, input logic [TIME_W-1:0] st,
			input logic [TN_W-1:0] tn, input logic [FN_W-1:0] fn, input logic [MN_W-1:0] mn,
			input bit drain);
		slot_item_t it;
		it = '{act: act, stamp: st, tn: tn, fn: fn, mn: mn, drain: drain};
		void'(track_slot(it, sh));
		pending.push_back(it);
	endtask

	// Input driver: pre-wait per item, optional drain before an item
	always @(posedge clk or negedge arst_n) begin
		track_t st;
		logic took;
		if (!arst_n) begin
			in_valid <= 1'b0;
			pre_wait = 0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				st = '{tx_stamp: exp_tx_stamp, tx_index: exp_tx_index,
					period: reg_period, lead: reg_lead};
				expected.push_back(track_slot(cur_item, st));
				exp_tx_stamp = st.tx_stamp;
				exp_tx_index = st.tx_index;
				n_sent <= n_sent + 1;
			end
			if (took || !in_valid) begin
				if (pre_wait != 0) begin
					pre_wait = pre_wait - 1;
					in_valid <= 1'b0;
				end else if (pending.size() != 0 &&
						!(pending[0].drain && (n_sent + int'(took) != n_recv))) begin
					cur_item = pending.pop_front();
					action <= cur_item.act;
					stamp <= cur_item.stamp;
					sync_tn <= cur_item.tn;
					sync_fn <= cur_item.fn;
					sync_mn <= cur_item.mn;
					in_valid <= 1'b1;
					pre_wait = pace_draw();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		slot_report_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else if (out_valid && !out_stall) begin
			n_recv <= n_recv + 1;
			if (expected.size() == 0) begin
				$error("result transfer with nothing expected");
				n_err++;
			end else begin
				want = expected.pop_front();
				if (fired !== want.fired) begin
					$error("fired: expected %0d, actual %0d", want.fired, fired);
					n_err++;
				end
				if (slot_stamp !== want.slot_stamp) begin
					$error("slot_stamp: expected %0h, actual %0h", want.slot_stamp, slot_stamp);
					n_err++;
				end
				if (offset !== want.offset) begin
					$error("offset: expected %0d, actual %0d", want.offset, offset);
					n_err++;
				end
				if (out_tn !== want.tn) begin
					$error("out_tn: expected %0d, actual %0d", want.tn, out_tn);
					n_err++;
				end
				if (out_fn !== want.fn) begin
					$error("out_fn: expected %0d, actual %0d", want.fn, out_fn);
					n_err++;
				end
				if (out_mn !== want.mn) begin
					$error("out_mn: expected %0d, actual %0d", want.mn, out_mn);
					n_err++;
				end
			end
			hold_left = pace_draw();
			out_stall <= (hold_left != 0);
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= (hold_left != 0);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		track_t sh;
		logic [TIME_W-1:0] p, lead, st, w;
		logic [REG_W-1:0] new_period, new_lead;
		logic [TN_W-1:0] tn;
		logic [FN_W-1:0] fn;
		logic [MN_W-1:0] mn;
		action_t act;
		int sel;
		bit drain;

		sh = '{tx_stamp: '0, tx_index: 0, period: SLOT_PERIOD_RST, lead: LEAD_TIME_RST};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset register values
		p = step_len(sh);
		lead = {32'd0, sh.lead};
		queue_item(sh, ACT_NONE, '1, '1, '1, '1, 1'b0);
		queue_item(sh, ACT_RX, '0, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_RX, '1, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_TICK, 64'd1000, '0, '0, '0, 1'b0);
		// lead boundary: exactly on it fires, one short does not
		queue_item(sh, ACT_TICK, sh.tx_stamp - lead, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_TICK, sh.tx_stamp - lead - 1, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_TICK, sh.tx_stamp - lead, '0, '0, '0, 1'b0);
		// half-slot ties on both sides, plain residuals, far burst
		queue_item(sh, ACT_RX, sh.tx_stamp + (p >> 1), '0, '0, '0, 1'b0);
		queue_item(sh, ACT_RX, sh.tx_stamp - (p >> 1), '0, '0, '0, 1'b0);
		queue_item(sh, ACT_RX, sh.tx_stamp + 5 * p + 3, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_RX, sh.tx_stamp - 3 * p - 7, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_RX, sh.tx_stamp + 64'h8000_0000_0000_0000, '0, '0, '0, 1'b0);
		// resync behind, ahead with numbers out of range, below range, top of range
		queue_item(sh, ACT_SYNC, sh.tx_stamp - 10 * p - 5, 3'd1, 5'd1, 6'd1, 1'b0);
		queue_item(sh, ACT_TICK, sh.tx_stamp - lead, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_SYNC, sh.tx_stamp + p, 3'd7, 5'd31, 6'd63, 1'b0);
		queue_item(sh, ACT_SYNC, sh.tx_stamp, 3'd0, 5'd0, 6'd0, 1'b0);
		queue_item(sh, ACT_SYNC, sh.tx_stamp, 3'd4, 5'd18, 6'd60, 1'b0);
		queue_item(sh, ACT_TICK, sh.tx_stamp - lead, '0, '0, '0, 1'b0);
		// time wrap: move slot time to the top, fire it so it wraps to zero, reseed
		queue_item(sh, ACT_SYNC, sh.tx_stamp + 64'h7FFF_FFFF_FFFF_FFFF - p,
			3'd2, 5'd9, 6'd30, 1'b0);
		queue_item(sh, ACT_SYNC, 64'd0 - 2 * p, 3'd1, 5'd1, 6'd1, 1'b0);
		queue_item(sh, ACT_TICK, sh.tx_stamp - lead, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_TICK, 64'hFFFF_FFFF_FFFF_FFF0, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_TICK, sh.tx_stamp - lead, '0, '0, '0, 1'b0);
		queue_item(sh, ACT_NONE, '0, '0, '0, '0, 1'b0);
		while (pending.size() != 0 || in_valid || n_recv != n_sent)
			@(posedge clk);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin new_period = SLOT_PERIOD_RST; new_lead = LEAD_TIME_RST; end
				1: begin new_period = 32'd1; new_lead = 32'd0; end
				2: begin new_period = 32'd0; new_lead = 32'd3; end
				3: begin new_period = '1; new_lead = '1; end
				4: begin new_period = 32'd1000; new_lead = 32'd999; end
				5: begin new_period = $urandom; new_lead = $urandom; end
				default: begin new_period = 32'd7; new_lead = '1; end
			endcase
			quiet = (ph == 1) || (ph == 4);

			// register writes while idle, back to back
			cfg_valid <= 1'b1;
			cfg_index <= REG_SLOT_PERIOD;
			cfg_data <= new_period;
			do @(posedge clk); while (!cfg_ready);
			reg_period = new_period;
			cfg_index <= REG_LEAD_TIME;
			cfg_data <= new_lead;
			do @(posedge clk); while (!cfg_ready);
			reg_lead = new_lead;
			cfg_valid <= 1'b0;
			sh.period = new_period;
			sh.lead = new_lead;

			// Random part: mostly well-paced ticks and bursts near the slot time
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				p = step_len(sh);
				lead = {32'd0, sh.lead};
				w = rand64();
				tn = TN_W'($urandom);
				fn = FN_W'($urandom);
				mn = MN_W'($urandom);
				drain = (i == 0) || ($urandom_range(0, 49) == 0);
				sel = int'($urandom_range(0, 99));
				if (sel < 55) begin
					act = ACT_TICK;
					if (sh.tx_stamp == '0)
						st = w;
					else begin
						case ($urandom_range(0, 9))
							0, 1, 2, 3, 4, 5: st = sh.tx_stamp - lead + w % ((p >> 2) + 1);
							6, 7: st = sh.tx_stamp - lead - 1 - w % p;
							8: st = sh.tx_stamp - lead;
							default: st = sh.tx_stamp + w % (4 * p);
						endcase
					end
				end else if (sel < 75) begin
					act = ACT_RX;
					case ($urandom_range(0, 3))
						0: st = sh.tx_stamp + w % (8 * p) - 4 * p;
						1: begin
							w = (p >> 1) + p * $urandom_range(0, 3);
							st = $urandom_range(0, 1) ? sh.tx_stamp + w : sh.tx_stamp - w;
						end
						2: st = sh.tx_stamp + w % p;
						default: st = w;
					endcase
				end else if (sel < 85) begin
					act = ACT_SYNC;
					if ($urandom_range(0, 9) != 0) begin
						tn = TN_W'($urandom_range(1, 4));
						fn = FN_W'($urandom_range(1, 18));
						mn = MN_W'($urandom_range(1, 60));
					end
					case ($urandom_range(0, 2))
						0: st = sh.tx_stamp - w % (64 * p);
						1: st = sh.tx_stamp + w % (4 * p);
						default: st = w;
					endcase
				end else if (sel < 90) begin
					act = ACT_NONE;
					st = w;
				end else begin
					// noise
					act = action_t'($urandom_range(0, 3));
					st = w;
				end
				queue_item(sh, act, st, tn, fn, mn, drain);
			end
			while (pending.size() != 0 || in_valid || n_recv != n_sent)
				@(posedge clk);
		end

		repeat (SETTLE) @(posedge clk);
		if (n_err == 0 && expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
src/tdma_stt_pkg.sv
src/tdma_slot_timing_tracker.sv
tb/tdma_slot_timing_tracker_tb.sv
